### hdl/xed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xed_pkg: shared types and constants of the xml entity decoder
// Match-state codes, the request bundle that passes from the match stage to
// the output serializer, and the prefix text tables.
// ----------------------------------------------------------------------------
package xed_pkg;

   // character codes
   localparam logic [7:0] CH_AMP  = 8'h26;  // &
   localparam logic [7:0] CH_APOS = 8'h27;  // '
   localparam logic [7:0] CH_QUOT = 8'h22;  // "
   localparam logic [7:0] CH_SEMI = 8'h3B;  // ;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_M    = 8'h6D;
   localparam logic [7:0] CH_P    = 8'h70;
   localparam logic [7:0] CH_O    = 8'h6F;
   localparam logic [7:0] CH_S    = 8'h73;
   localparam logic [7:0] CH_Q    = 8'h71;
   localparam logic [7:0] CH_U    = 8'h75;
   localparam logic [7:0] CH_T    = 8'h74;

   // matched prefix so far
   typedef enum logic [3:0] {
      ST_IDLE  = 4'd0,   // no partial match
      ST_AMP   = 4'd1,   // "&"
      ST_A     = 4'd2,   // "&a"
      ST_AM    = 4'd3,   // "&am"
      ST_AMPP  = 4'd4,   // "&amp"
      ST_AP    = 4'd5,   // "&ap"
      ST_APO   = 4'd6,   // "&apo"
      ST_APOS  = 4'd7,   // "&apos"
      ST_Q     = 4'd8,   // "&q"
      ST_QU    = 4'd9,   // "&qu"
      ST_QUO   = 4'd10,  // "&quo"
      ST_QUOT  = 4'd11   // "&quot"
   } match_state_type;

   // results of one request: optional prefix text, then an optional byte
   typedef struct packed {
      match_state_type pfx;       // prefix to replay, idle for none
      logic            has_byte;  // one more byte after the prefix
      logic [7:0]      data;      // that byte
      logic            last;      // request closed the string
      logic            load;      // at least one result
   } bundle_type;

   // length of the prefix text of a state
   function automatic logic [2:0] pfx_len(input match_state_type st);
      logic [2:0] len;
      unique case (st)
         ST_AMP:                    len = 3'd1;
         ST_A, ST_Q:                len = 3'd2;
         ST_AM, ST_AP, ST_QU:       len = 3'd3;
         ST_AMPP, ST_APO, ST_QUO:   len = 3'd4;
         ST_APOS, ST_QUOT:          len = 3'd5;
         default:                   len = 3'd0;
      endcase
      return len;
   endfunction

   // character at position idx of the prefix text of a state
   function automatic logic [7:0] pfx_char(input match_state_type st,
                                           input logic [2:0] idx);
      logic [39:0] txt;
      logic [7:0]  ch;
      unique case (st)
         ST_AMP:  txt = {CH_AMP, 32'h0};
         ST_A:    txt = {CH_AMP, CH_A, 24'h0};
         ST_AM:   txt = {CH_AMP, CH_A, CH_M, 16'h0};
         ST_AMPP: txt = {CH_AMP, CH_A, CH_M, CH_P, 8'h0};
         ST_AP:   txt = {CH_AMP, CH_A, CH_P, 16'h0};
         ST_APO:  txt = {CH_AMP, CH_A, CH_P, CH_O, 8'h0};
         ST_APOS: txt = {CH_AMP, CH_A, CH_P, CH_O, CH_S};
         ST_Q:    txt = {CH_AMP, CH_Q, 24'h0};
         ST_QU:   txt = {CH_AMP, CH_Q, CH_U, 16'h0};
         ST_QUO:  txt = {CH_AMP, CH_Q, CH_U, CH_O, 8'h0};
         ST_QUOT: txt = {CH_AMP, CH_Q, CH_U, CH_O, CH_T};
         default: txt = 40'h0;
      endcase
      unique case (idx)
         3'd0:    ch = txt[39:32];
         3'd1:    ch = txt[31:24];
         3'd2:    ch = txt[23:16];
         3'd3:    ch = txt[15:8];
         3'd4:    ch = txt[7:0];
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

### hdl/xml_entity_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_decoder: streaming decoder for &amp; &apos; and &quot;
// Takes a string one byte per request and gives the decoded bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - request channel req_valid/req_ready carries req_byte and req_last; set
//    req_last on the final byte of each string
//  - response channel rsp_valid/rsp_ready carries rsp_byte, rsp_run_end on
//    the last result caused by one request, rsp_string_end on the last
//    result of a string
//  - a request extending a partial entity match gives no result unless it
//    ends the string; a failed match replays the held prefix text, up to six
//    results in all
//  - a request passes the request register, then the result register
//  - throughput: one request per cycle while the receiver is ready and each
//    gives at most one result; more results keep the single output register busy
//  - a stalled receiver keeps the result register full; one more request
//    waits in the request register, then req_ready drops
//  - reset clears both registers and returns the matcher to no match
// ----------------------------------------------------------------------------
module xml_entity_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte,
   output logic            rsp_run_end,
   output logic            rsp_string_end
);
   import xed_pkg::*;

   logic            emit_ready;
   logic            bundle_valid;
   bundle_type      bundle;
   match_state_type match_state;

   // prefix matcher
   xed_match u_match (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_byte     (req_byte),
      .req_last     (req_last),
      .emit_ready   (emit_ready),
      .bundle_valid (bundle_valid),
      .bundle       (bundle),
      .match_state  (match_state)
   );

   // output serializer
   xed_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .bundle_valid   (bundle_valid),
      .bundle         (bundle),
      .emit_ready     (emit_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte       (rsp_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   // a request ending the string always yields results
   a_last_loads: assert property (@(posedge clock) disable iff (reset)
      bundle_valid && bundle.last |-> bundle.load)
      else $error("string end request without results");

   // matcher returns to idle after the string ends
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      bundle_valid && emit_ready && bundle.last |=> match_state == ST_IDLE)
      else $error("match state not cleared at string end");

   // an empty serializer never blocks the matcher
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> emit_ready)
      else $error("serializer empty but not ready");

   // string end only on the last result of a request
   a_string_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_end)
      else $error("string end without run end");

endmodule
`default_nettype wire

### hdl/xed_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xed_match: request register and entity prefix matcher
// Holds one request and the match state, and turns the request into a
// bundle of results for the output serializer.
// ----------------------------------------------------------------------------
module xed_match (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_byte,
   input  wire logic                     req_last,
   input  wire logic                     emit_ready,
   output logic                          bundle_valid,
   output xed_pkg::bundle_type           bundle,
   output xed_pkg::match_state_type      match_state
);
   import xed_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   match_state_type state_ff;
   match_state_type state_in;

   logic            advance;
   match_state_type ext_state;
   logic            ext_done;
   logic [7:0]      done_char;
   logic            ext_cont;
   logic            is_amp;

   // request register, refilled when empty or whenever its content moves on
   assign advance   = in_valid_ff & emit_ready;
   assign req_ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte;
         in_last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // does the byte extend or complete the current prefix
   always_comb begin
      ext_state = ST_IDLE;
      ext_done  = 1'b0;
      done_char = CH_AMP;
      unique case (state_ff)
         ST_AMP: begin
            if (in_byte_ff == CH_A) ext_state = ST_A;
            else if (in_byte_ff == CH_Q) ext_state = ST_Q;
         end
         ST_A: begin
            if (in_byte_ff == CH_M) ext_state = ST_AM;
            else if (in_byte_ff == CH_P) ext_state = ST_AP;
         end
         ST_AM:  if (in_byte_ff == CH_P) ext_state = ST_AMPP;
         ST_AP:  if (in_byte_ff == CH_O) ext_state = ST_APO;
         ST_APO: if (in_byte_ff == CH_S) ext_state = ST_APOS;
         ST_Q:   if (in_byte_ff == CH_U) ext_state = ST_QU;
         ST_QU:  if (in_byte_ff == CH_O) ext_state = ST_QUO;
         ST_QUO: if (in_byte_ff == CH_T) ext_state = ST_QUOT;
         ST_AMPP: begin
            ext_done  = (in_byte_ff == CH_SEMI);
            done_char = CH_AMP;
         end
         ST_APOS: begin
            ext_done  = (in_byte_ff == CH_SEMI);
            done_char = CH_APOS;
         end
         ST_QUOT: begin
            ext_done  = (in_byte_ff == CH_SEMI);
            done_char = CH_QUOT;
         end
         default: ;
      endcase
   end

   assign ext_cont = (ext_state != ST_IDLE);
   // an ampersand opens a new match unless the string ends here
   assign is_amp   = (in_byte_ff == CH_AMP) & ~in_last_ff;

   // next match state
   always_comb begin
      state_in = ST_IDLE;
      priority if (state_ff == ST_IDLE) begin
         if (is_amp) state_in = ST_AMP;
      end else if (ext_done) begin
         state_in = ST_IDLE;
      end else if (ext_cont) begin
         state_in = ext_state;
      end else begin
         if (is_amp) state_in = ST_AMP;
      end
      if (in_last_ff) state_in = ST_IDLE;
   end

   // results of this request
   always_comb begin
      bundle          = '0;
      bundle.pfx      = ST_IDLE;
      bundle.data     = in_byte_ff;
      bundle.last     = in_last_ff;
      priority if (state_ff == ST_IDLE) begin
         bundle.has_byte = ~is_amp;
      end else if (ext_done) begin
         bundle.has_byte = 1'b1;
         bundle.data     = done_char;
      end else if (ext_cont) begin
         if (in_last_ff) bundle.pfx = ext_state;
      end else begin
         bundle.pfx      = state_ff;
         bundle.has_byte = ~is_amp;
      end
      bundle.load = (bundle.pfx != ST_IDLE) | bundle.has_byte;
   end

   assign bundle_valid = in_valid_ff;
   assign match_state  = state_ff;

endmodule
`default_nettype wire

### hdl/xed_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xed_emit: result register and output serializer
// Holds one bundle and sends its prefix bytes and final byte one result per
// cycle while rsp_ready holds, flagging the last result of request and string.
// ----------------------------------------------------------------------------
module xed_emit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                bundle_valid,
   input  wire xed_pkg::bundle_type bundle,
   output logic                     emit_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_byte,
   output logic                     rsp_run_end,
   output logic                     rsp_string_end
);
   import xed_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   bundle_type buf_ff;

   logic [2:0] pre_len;
   logic [2:0] count;
   logic       run_end;
   logic       load;

   // position within the held bundle
   assign pre_len = pfx_len(buf_ff.pfx);
   assign count   = pre_len + {2'b00, buf_ff.has_byte};
   assign run_end = (idx_ff == (count - 3'd1));

   assign emit_ready = ~valid_ff | (rsp_ready & run_end);
   assign load       = bundle_valid & emit_ready & bundle.load;

   // serializer control
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      priority if (load) begin
         valid_in = 1'b1;
         idx_in   = 3'd0;
      end else if (valid_ff && rsp_ready) begin
         if (run_end) valid_in = 1'b0;
         idx_in = idx_ff + 3'd1;
      end else begin
         // hold the current position
         valid_in = valid_ff;
         idx_in   = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= bundle;
      end
   end

   // result fields
   assign rsp_valid      = valid_ff;
   assign rsp_byte       = (idx_ff < pre_len) ? pfx_char(buf_ff.pfx, idx_ff) : buf_ff.data;
   assign rsp_run_end    = run_end;
   assign rsp_string_end = run_end & buf_ff.last;

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the xml entity decoder
// Sends text strings byte by byte, predicts the decoded bytes with a local
// prefix matcher and compares every response field in order. Covers byte
// extremes, the three entities, failed matches, end-of-string flushes, random
// strings with idle bursts on both sides and a long receiver hold.
// ----------------------------------------------------------------------------
module tb;

   import xed_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake
   localparam int HOLD_CYCLES    = 120;   // long receiver hold
   localparam int DRAIN_CYCLES   = 8;     // settle time after the last response
   localparam int RANDOM_ITEMS   = 330;
   localparam int PRESSURE_ITEMS = 40;
   localparam int TOTAL_ITEMS    = 450;

   typedef enum logic [1:0] {
      GROW_MISS,
      GROW_MORE,
      GROW_DONE
   } grow_kind_type;

   typedef struct packed {
      grow_kind_type   kind;
      match_state_type next_st;
      logic [7:0]      ch;
   } grow_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       string_end;
   } decoded_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_byte;
   logic       rsp_run_end;
   logic       rsp_string_end;

   // predictor state and expected responses
   match_state_type  entity_state = ST_IDLE;
   decoded_char_type decoded_fifo[$];
   logic [7:0]       text_buf[$];

   int  items_sent = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   bit  req_gaps_on = 1'b0;
   logic rsp_stalls_on = 1'b0;
   logic hold_req = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;
   int  run_left = 0;

   logic [7:0] entity_letters [0:9] = '{CH_AMP, CH_A, CH_M, CH_P, CH_O,
                                        CH_S, CH_Q, CH_U, CH_T, CH_SEMI};

   xml_entity_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte       (req_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte       (rsp_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end)
   );

   always #5 clock = ~clock;

   // text held by each partial match state
   function automatic string prefix_text(input match_state_type st);
      string s;
      case (st)
         ST_AMP:  s = "&";
         ST_A:    s = "&a";
         ST_AM:   s = "&am";
         ST_AMPP: s = "&amp";
         ST_AP:   s = "&ap";
         ST_APO:  s = "&apo";
         ST_APOS: s = "&apos";
         ST_Q:    s = "&q";
         ST_QU:   s = "&qu";
         ST_QUO:  s = "&quo";
         ST_QUOT: s = "&quot";
         default: s = "";
      endcase
      return s;
   endfunction

   // one byte against a pending match: miss, longer prefix, or a whole entity
   function automatic grow_type grow_match(input match_state_type st,
                                           input logic [7:0] b);
      grow_type g;
      g = '{kind: GROW_MISS, next_st: ST_IDLE, ch: 8'h00};
      case (st)
         ST_AMP: begin
            if (b == CH_A) g = '{GROW_MORE, ST_A, 8'h00};
            else if (b == CH_Q) g = '{GROW_MORE, ST_Q, 8'h00};
         end
         ST_A: begin
            if (b == CH_M) g = '{GROW_MORE, ST_AM, 8'h00};
            else if (b == CH_P) g = '{GROW_MORE, ST_AP, 8'h00};
         end
         ST_AM:   if (b == CH_P) g = '{GROW_MORE, ST_AMPP, 8'h00};
         ST_AMPP: if (b == CH_SEMI) g = '{GROW_DONE, ST_IDLE, CH_AMP};
         ST_AP:   if (b == CH_O) g = '{GROW_MORE, ST_APO, 8'h00};
         ST_APO:  if (b == CH_S) g = '{GROW_MORE, ST_APOS, 8'h00};
         ST_APOS: if (b == CH_SEMI) g = '{GROW_DONE, ST_IDLE, CH_APOS};
         ST_Q:    if (b == CH_U) g = '{GROW_MORE, ST_QU, 8'h00};
         ST_QU:   if (b == CH_O) g = '{GROW_MORE, ST_QUO, 8'h00};
         ST_QUO:  if (b == CH_T) g = '{GROW_MORE, ST_QUOT, 8'h00};
         ST_QUOT: if (b == CH_SEMI) g = '{GROW_DONE, ST_IDLE, CH_QUOT};
         default: ;
      endcase
      return g;
   endfunction

   // decode one accepted request and queue the bytes it must produce
   task automatic decode_expect(input logic [7:0] b, input logic last);
      logic [7:0]      out_chars[$];
      match_state_type st;
      grow_type        g;
      string           pfx;
      st = entity_state;
      pfx = "";
      if (st != ST_IDLE) begin
         g = grow_match(st, b);
         case (g.kind)
            GROW_DONE: begin
               out_chars.push_back(g.ch);
               st = ST_IDLE;
            end
            GROW_MORE: begin
               st = g.next_st;
               if (last) begin
                  pfx = prefix_text(st);
                  st = ST_IDLE;
               end
            end
            default: begin
               pfx = prefix_text(st);
               st = ST_IDLE;
            end
         endcase
         for (int i = 0; i < pfx.len(); i++) out_chars.push_back(pfx[i]);
         if (g.kind == GROW_MISS) begin
            if (b == CH_AMP && !last) st = ST_AMP;
            else out_chars.push_back(b);
         end
      end else begin
         if (b == CH_AMP && !last) st = ST_AMP;
         else out_chars.push_back(b);
      end
      if (last) st = ST_IDLE;
      entity_state = st;
      for (int i = 0; i < out_chars.size(); i++) begin
         decoded_fifo.push_back('{data:       out_chars[i],
                                  run_end:    (i == out_chars.size() - 1),
                                  string_end: (i == out_chars.size() - 1) && last});
      end
   endtask

   // offer one request and hold it until accepted, then maybe go idle
   task automatic send_char(input logic [7:0] b, input logic last);
      req_valid <= 1'b1;
      req_byte  <= b;
      req_last  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_expect(b, last);
      items_sent++;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // send the buffered text as one string
   task automatic send_buffer();
      for (int i = 0; i < text_buf.size(); i++)
         send_char(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      send_buffer();
   endtask

   // random string built from entities, broken prefixes and loose bytes
   task automatic send_random_string();
      match_state_type st;
      string           s;
      int              pieces;
      pieces = $urandom_range(1, 6);
      for (int p = 0; p < pieces; p++) begin
         s = "";
         case ($urandom_range(0, 6))
            0, 1: begin
               case ($urandom_range(0, 2))
                  0:       st = ST_AMPP;
                  1:       st = ST_APOS;
                  default: st = ST_QUOT;
               endcase
               s = {prefix_text(st), ";"};
            end
            2: begin
               st = match_state_type'($urandom_range(ST_AMP, ST_QUOT));
               s = prefix_text(st);
            end
            3: text_buf.push_back(CH_AMP);
            4: text_buf.push_back(entity_letters[$urandom_range(0, 9)]);
            default: text_buf.push_back(8'($urandom_range(0, 255)));
         endcase
         for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      end
      send_buffer();
   endtask

   // response checker
   always @(posedge clock) begin
      decoded_char_type exp_char;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_fifo.size() == 0) begin
            $error("unexpected response: rsp_byte %h", rsp_byte);
            mismatches++;
         end else begin
            exp_char = decoded_fifo.pop_front();
            if (rsp_byte !== exp_char.data) begin
               $error("rsp_byte expected %h actual %h", exp_char.data, rsp_byte);
               mismatches++;
            end
            if (rsp_run_end !== exp_char.run_end) begin
               $error("rsp_run_end expected %b actual %b", exp_char.run_end, rsp_run_end);
               mismatches++;
            end
            if (rsp_string_end !== exp_char.string_end) begin
               $error("rsp_string_end expected %b actual %b",
                      exp_char.string_end, rsp_string_end);
               mismatches++;
            end
         end
      end
   end

   // receiver: long hold on request, random stall bursts, ready runs
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req  <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (run_left != 0) begin
         run_left  <= run_left - 1;
         rsp_ready <= 1'b1;
      end else if (rsp_stalls_on && $urandom_range(0, 2) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready  <= 1'b0;
      end else begin
         run_left  <= $urandom_range(0, 19);
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("xml_entity_decoder regression: fail");
            $finish;
         end
      end
   end

   // plain bytes at the value extremes, zero byte mid-string
   task automatic test_byte_extremes();
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
   endtask

   // whole entities ending the string
   task automatic test_entities();
      send_text("&amp;");
      send_text("&apos;");
   endtask

   // longest prefix broken by a plain byte, and an ampersand after a miss
   task automatic test_failed_match();
      send_text("&quotx");
      send_text("&a&p");
   endtask

   // string ends inside a match or on a lone ampersand
   task automatic test_end_flush();
      send_text("&q");
      send_text("&");
   endtask

   task automatic test_random_strings();
      req_gaps_on = 1'b1;
      rsp_stalls_on <= 1'b1;
      while (items_sent < RANDOM_ITEMS) send_random_string();
   endtask

   // receiver holds while the sender keeps offering
   task automatic test_backpressure();
      int stop_at;
      stop_at = items_sent + PRESSURE_ITEMS;
      req_gaps_on = 1'b0;
      hold_req <= 1'b1;
      while (items_sent < stop_at) send_random_string();
   endtask

   // full rate on both sides
   task automatic test_full_rate();
      req_gaps_on = 1'b0;
      rsp_stalls_on <= 1'b0;
      while (items_sent < TOTAL_ITEMS) send_random_string();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_byte_extremes();
      test_entities();
      test_failed_match();
      test_end_flush();
      test_random_strings();
      test_backpressure();
      test_full_rate();
      req_valid <= 1'b0;
      while (decoded_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("xml_entity_decoder regression: pass");
      else
         $display("xml_entity_decoder regression: fail");
      $finish;
   end

endmodule

### xml_entity_decoder.f
hdl/xed_pkg.sv
hdl/xed_match.sv
hdl/xed_emit.sv
hdl/xml_entity_decoder.sv
verif/tb.sv
